// ----- rtl/rsltab_pkg.sv -----
// ============================================================================
// rsltab_pkg: shared constants for the retransmit slot table
// Command, status and register codes, field widths and stream widths.
// ============================================================================
`default_nettype none

package rsltab_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TAG_WIDTH_DEF = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned TAG_IN_W = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned S_TDATA_W = 88;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;
  localparam logic [CNT_W-1:0] MAX_SENDS_RST = 8'd3;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;

  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_SERVED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_HELD    = 3'd4;
  localparam logic [STAT_W-1:0] ST_TAGFREE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE    = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/retransmit_slot_table.sv -----
// ============================================================================
// retransmit_slot_table: transmit slot table with interval-paced service
// Add, service tick and free-by-tag over SLOTS slots, scanning the slots in turn.
// ============================================================================
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser command, tdata fields
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser status, tdata fields
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
//  The slot scan steps one slot index at a time through the shared compare
//  and the single read port of the descriptor RAM.
//  Reset clears the slot flags at once; there is no clearing pass.
//  A new request is taken only once the previous result has been taken.
//
`default_nettype none

module retransmit_slot_table
  import rsltab_pkg::*;
#(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [31:0] time_now, [47:32] payload_handle, [63:48] msg_length,
  // [64] retransmit, [65] manual_clear, [81:66] tag, [82] lower_layer_done
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  wire logic [CMD_W-1:0]      s_axis_tuser,

  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [3:0] slot, [4] send_now, [20:5] send_handle, [36:21] send_length,
  // [37] slot_freed, [42:38] freed_count, [47:43] used_count
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  // [2:0] status
  output logic [STAT_W-1:0]          m_axis_tuser,

  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam int unsigned CNT_LO = 0;
  localparam int unsigned TAG_LO = CNT_LO + CNT_W;
  localparam int unsigned LEN_LO = TAG_LO + TAG_WIDTH;
  localparam int unsigned HND_LO = LEN_LO + LEN_W;
  localparam int unsigned RW     = HND_LO + HANDLE_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD     = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_SERVE   = 4'd4;
  localparam logic [3:0] S_TAG     = 4'd5;
  localparam logic [3:0] S_TAG_CMP = 4'd6;

  // configuration
  logic [IVL_W-1:0] interval_q;
  logic [CNT_W-1:0] max_sends_q;
  logic             rotate_q;

  // control
  logic [3:0]       state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    fcnt_q, fcnt_d;
  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] sent_q, sent_d;
  logic [SLOTS-1:0] retx_q, retx_d;
  logic [SLOTS-1:0] manual_q, manual_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [TIME_W-1:0] last_time_q, last_time_d;
  logic [IW-1:0]    scan_start_q, scan_start_d;
  logic             out_valid_q;

  // request fields
  logic [CMD_W-1:0]    cmd_q;
  logic [TIME_W-1:0]   time_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [LEN_W-1:0]    length_q;
  logic                retx_in_q;
  logic                manual_in_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic                done_q;

  // result fields
  logic                out_load;
  logic [STAT_W-1:0]   out_status_d, out_status_q;
  logic [SLOT_W-1:0]   out_slot_d, out_slot_q;
  logic                out_send_d, out_send_q;
  logic [HANDLE_W-1:0] out_handle_d, out_handle_q;
  logic [LEN_W-1:0]    out_length_d, out_length_q;
  logic                out_freed_d, out_freed_q;
  logic [COUNT_W-1:0]  out_fcnt_d, out_fcnt_q;
  logic [COUNT_W-1:0]  out_used_d, out_used_q;

  // descriptor RAM
  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic                 s_fire;
  logic [TIME_W:0]      due;
  logic [CNT_W-1:0]     rd_cnt;
  logic [CNT_W-1:0]     cnt_new;
  logic                 send;
  logic                 release_srv;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign cfg_ready_o   = 1'b1;

  assign due     = {1'b0, last_time_q} + (TIME_W + 1)'(interval_q);
  assign rd_cnt  = ram_rdata[CNT_LO +: CNT_W];
  assign send    = !sent_q[idx_q] || retx_q[idx_q];
  assign cnt_new = (send && (rd_cnt != CNT_MAX)) ? rd_cnt + 1'b1 : rd_cnt;
  assign release_srv = (send && done_q) ||
                       (!manual_q[idx_q] && ((cnt_new > max_sends_q) || !retx_q[idx_q]));

  rsltab_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    fcnt_d       = fcnt_q;
    used_d       = used_q;
    sent_d       = sent_q;
    retx_d       = retx_q;
    manual_d     = manual_q;
    occ_d        = occ_q;
    last_time_d  = last_time_q;
    scan_start_d = scan_start_q;
    ram_we       = 1'b0;
    ram_wdata    = {handle_q, length_q, tag_q, {CNT_W{1'b0}}};
    out_load     = 1'b0;
    out_status_d = ST_NONE;
    out_slot_d   = '0;
    out_send_d   = 1'b0;
    out_handle_d = '0;
    out_length_d = '0;
    out_freed_d  = 1'b0;
    out_fcnt_d   = '0;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          idx_d  = '0;
          fcnt_d = '0;
          case (s_axis_tuser)
            CMD_ADD:  state_d = S_ADD;
            CMD_TICK: state_d = S_CHECK;
            CMD_FREE: state_d = S_TAG;
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_ADD: begin
        if (!used_q[idx_q]) begin
          ram_we           = 1'b1;
          used_d[idx_q]    = 1'b1;
          sent_d[idx_q]    = 1'b0;
          retx_d[idx_q]    = retx_in_q;
          manual_d[idx_q]  = manual_in_q;
          occ_d            = occ_q + 1'b1;
          out_load         = 1'b1;
          out_status_d     = ST_ADDED;
          out_slot_d       = SLOT_W'(idx_q);
          state_d          = S_IDLE;
        end else if (idx_q == LAST) begin
          out_load     = 1'b1;
          out_status_d = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_CHECK: begin
        if (due > {1'b0, time_q}) begin
          out_load     = 1'b1;
          out_status_d = ST_HELD;
          state_d      = S_IDLE;
        end else begin
          last_time_d = time_q;
          idx_d       = rotate_q ? scan_start_q : '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (used_q[idx_q]) begin
          state_d = S_SERVE;
        end else if (idx_q == LAST) begin
          scan_start_d = '0;
          out_load     = 1'b1;
          out_status_d = ST_NONE;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SERVE: begin
        out_load     = 1'b1;
        out_status_d = ST_SERVED;
        out_slot_d   = SLOT_W'(idx_q);
        out_freed_d  = release_srv;
        if (send) begin
          ram_we        = 1'b1;
          ram_wdata     = {ram_rdata[RW-1:TAG_LO], cnt_new};
          sent_d[idx_q] = 1'b1;
          out_send_d    = 1'b1;
          out_handle_d  = ram_rdata[HND_LO +: HANDLE_W];
          out_length_d  = ram_rdata[LEN_LO +: LEN_W];
        end
        if (release_srv) begin
          used_d[idx_q]   = 1'b0;
          sent_d[idx_q]   = 1'b0;
          retx_d[idx_q]   = 1'b0;
          manual_d[idx_q] = 1'b0;
          occ_d           = occ_q - 1'b1;
        end
        if (rotate_q) begin
          scan_start_d = (idx_q == LAST) ? '0 : idx_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      S_TAG: begin
        if (used_q[idx_q]) begin
          state_d = S_TAG_CMP;
        end else if (idx_q == LAST) begin
          out_load     = 1'b1;
          out_status_d = ST_TAGFREE;
          out_fcnt_d   = COUNT_W'(fcnt_q);
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TAG_CMP: begin
        if (ram_rdata[TAG_LO +: TAG_WIDTH] == tag_q) begin
          used_d[idx_q]   = 1'b0;
          sent_d[idx_q]   = 1'b0;
          retx_d[idx_q]   = 1'b0;
          manual_d[idx_q] = 1'b0;
          occ_d           = occ_q - 1'b1;
          fcnt_d          = fcnt_q + 1'b1;
        end
        if (idx_q == LAST) begin
          out_load     = 1'b1;
          out_status_d = ST_TAGFREE;
          out_fcnt_d   = COUNT_W'(fcnt_d);
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_TAG;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_used_d = COUNT_W'(occ_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      fcnt_q       <= '0;
      used_q       <= '0;
      sent_q       <= '0;
      retx_q       <= '0;
      manual_q     <= '0;
      occ_q        <= '0;
      last_time_q  <= '0;
      scan_start_q <= '0;
      out_valid_q  <= 1'b0;
      interval_q   <= '0;
      max_sends_q  <= MAX_SENDS_RST;
      rotate_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      fcnt_q       <= fcnt_d;
      used_q       <= used_d;
      sent_q       <= sent_d;
      retx_q       <= retx_d;
      manual_q     <= manual_d;
      occ_q        <= occ_d;
      last_time_q  <= last_time_d;
      scan_start_q <= scan_start_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_INTERVAL:  interval_q  <= cfg_data_i[IVL_W-1:0];
          REG_MAX_SENDS: max_sends_q <= cfg_data_i[CNT_W-1:0];
          REG_ROTATE:    rotate_q    <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q       <= s_axis_tuser;
      time_q      <= s_axis_tdata[31:0];
      handle_q    <= s_axis_tdata[47:32];
      length_q    <= s_axis_tdata[63:48];
      retx_in_q   <= s_axis_tdata[64];
      manual_in_q <= s_axis_tdata[65];
      tag_q       <= TAG_WIDTH'(s_axis_tdata[81:66]);
      done_q      <= s_axis_tdata[82];
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_send_q   <= out_send_d;
      out_handle_q <= out_handle_d;
      out_length_q <= out_length_d;
      out_freed_q  <= out_freed_d;
      out_fcnt_q   <= out_fcnt_d;
      out_used_q   <= out_used_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_used_q, out_fcnt_q, out_freed_q, out_length_q,
                          out_handle_q, out_send_q, out_slot_q};

`ifndef SYNTH
  a_occ_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CW'($countones(used_q)))
    else $error("occupancy count differs from used slots");

  a_serve_on_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SERVE || state_q == S_TAG_CMP) |-> used_q[idx_q])
    else $error("serving or matching a free slot");

  a_add_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD && ram_we) |=> used_q[$past(idx_q)])
    else $error("added slot not marked used");

  a_tick_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (cmd_q == CMD_TICK && !out_valid_q))
    else $error("interval check outside a service tick");
`endif

endmodule

`default_nettype wire

// ----- rtl/rsltab_ram.sv -----
// ============================================================================
// rsltab_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module rsltab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
